// ===== sv/rkrs_pkg.sv =====
package rkrs_pkg;

   // Request kinds
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BASE = 1'b1;

   // ASCII codes of interest
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_C_UP = 8'h43;
   localparam logic [7:0] CHAR_G_UP = 8'h47;
   localparam logic [7:0] CHAR_T_UP = 8'h54;
   localparam logic [7:0] CHAR_N_UP = 8'h4E;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_C_LO = 8'h63;
   localparam logic [7:0] CHAR_G_LO = 8'h67;
   localparam logic [7:0] CHAR_T_LO = 8'h74;
   localparam logic [7:0] CHAR_N_LO = 8'h6E;

   // 2-bit nucleotide codes
   typedef logic [1:0] base_code_type;
   localparam base_code_type CODE_A = 2'd0;
   localparam base_code_type CODE_C = 2'd1;
   localparam base_code_type CODE_G = 2'd2;
   localparam base_code_type CODE_T = 2'd3;

   // Anything other than C, G or T (either case) codes as A
   function automatic base_code_type base_code(input logic [7:0] ch);
      base_code_type code;
      case (ch)
         CHAR_C_UP, CHAR_C_LO: code = CODE_C;
         CHAR_G_UP, CHAR_G_LO: code = CODE_G;
         CHAR_T_UP, CHAR_T_LO: code = CODE_T;
         default:              code = CODE_A;
      endcase
      return code;
   endfunction

   function automatic logic is_n_char(input logic [7:0] ch);
      return (ch == CHAR_N_UP) || (ch == CHAR_N_LO);
   endfunction

endpackage

// ===== sv/rkrs_ram.sv =====
module rkrs_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/repeat_kmer_read_screen.sv =====
// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    op, entry_index, kmer_entry, base_char, read_end
// rsp_      out        rsp_valid / rsp_stall    read_has_repeat
// csr_      in         csr_write_enable         csr_write_data (table_count)
//
// A load request writes one table entry if its index lies inside the table. A
// base request shifts the base into the window; a tested window runs up to
// log2(count)+1 binary search probes on the one table memory port, then reads
// the found entry; a read end then posts the response. New requests stall while
// the block searches or posts a response. Reset is synchronous, clears the read
// state and the table count; table contents stay undefined until loaded. A stalled
// response holds in the output register while the next requests are taken.
module repeat_kmer_read_screen
   import rkrs_pkg::*;
#(
   parameter int TABLE_DEPTH = 65536,
   parameter int KMER_LEN    = 11
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_entry_index,
   input  logic [21:0] req_kmer_entry,
   input  logic [7:0]  req_base_char,
   input  logic        req_read_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_read_has_repeat,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);

   localparam int KW   = 2 * KMER_LEN;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CNTW = $clog2(TABLE_DEPTH + 1);
   localparam int SW   = $clog2(KMER_LEN + 1);
   localparam int BW   = $clog2(KMER_LEN);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_CHECK  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]      state_ff, state_in;
   logic [16:0]     count_cfg_ff;
   logic [KW-1:0]   window_ff, window_in;
   logic [SW-1:0]   bases_ff, bases_in;
   logic [BW-1:0]   blackout_ff, blackout_in;
   logic            hit_ff, hit_in;
   logic            last_ff, last_in;
   logic [CNTW-1:0] lo_ff, lo_in;
   logic [CNTW-1:0] hi_ff, hi_in;
   logic [CNTW-1:0] mid_ff, mid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_hit_ff, rsp_hit_in;

   logic [CNTW-1:0] count;
   logic            accept;
   logic            ram_we;
   logic [AW-1:0]   ram_addr;
   logic [KW-1:0]   ram_rdata;

   // Probe candidates, computed beside the compare
   logic            less;
   logic [CNTW-1:0] mid_up, mid_dn, mid_plus1;
   logic            up_open, dn_open;

   logic [KW-1:0]   win_next;
   logic [SW-1:0]   bases_next;
   logic            out_free;

   // Effective table count, saturated to the table depth
   assign count = (32'(count_cfg_ff) > 32'(TABLE_DEPTH)) ? CNTW'(TABLE_DEPTH)
                                                        : CNTW'(count_cfg_ff);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign win_next   = {window_ff[KW-3:0], base_code(req_base_char)};
   assign bases_next = (bases_ff < SW'(KMER_LEN)) ? bases_ff + 1'b1 : bases_ff;

   assign less      = ram_rdata < window_ff;
   assign mid_plus1 = mid_ff + 1'b1;
   assign mid_up    = mid_plus1 + ((hi_ff - mid_plus1) >> 1);
   assign mid_dn    = lo_ff + ((mid_ff - lo_ff) >> 1);
   assign up_open   = mid_plus1 < hi_ff;
   assign dn_open   = lo_ff < mid_ff;

   // Table memory
   assign ram_we = accept && (req_op == OP_LOAD) && (32'(req_entry_index) < 32'(TABLE_DEPTH));

   rkrs_ram #(
      .WIDTH (KW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (KW'(req_kmer_entry)),
      .rdata (ram_rdata)
   );

   // Control and search step
   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      bases_in     = bases_ff;
      blackout_in  = blackout_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      ram_addr     = AW'(mid_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_op == OP_LOAD) begin
               ram_addr = AW'(req_entry_index);
            end else begin
               ram_addr = AW'(count >> 1);
            end
            if (accept && (req_op == OP_BASE)) begin
               window_in = win_next;
               bases_in  = bases_next;
               last_in   = req_read_end;
               lo_in     = '0;
               hi_in     = count;
               mid_in    = count >> 1;
               if (is_n_char(req_base_char)) begin
                  blackout_in = BW'(KMER_LEN - 1);
               end else if (blackout_ff != '0) begin
                  blackout_in = blackout_ff - 1'b1;
               end
               if (!is_n_char(req_base_char) && (blackout_ff == '0) &&
                   (bases_next == SW'(KMER_LEN)) && (count != '0)) begin
                  state_in = ST_SEARCH;
               end else if (req_read_end) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SEARCH: begin
            // Data for mid_ff is on the memory output now
            if (less) begin
               lo_in    = mid_plus1;
               mid_in   = mid_up;
               ram_addr = AW'(mid_up);
               if (!up_open) begin
                  ram_addr = AW'(mid_plus1);
                  if (mid_plus1 < count) begin
                     state_in = ST_CHECK;
                  end else begin
                     state_in = last_ff ? ST_FINISH : ST_IDLE;
                  end
               end
            end else begin
               hi_in    = mid_ff;
               mid_in   = mid_dn;
               ram_addr = AW'(mid_dn);
               if (!dn_open) begin
                  ram_addr = AW'(lo_ff);
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            if (ram_rdata == window_ff) begin
               hit_in = 1'b1;
            end
            state_in = last_ff ? ST_FINISH : ST_IDLE;
         end

         ST_FINISH: begin
            // Post the response once the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               window_in    = '0;
               bases_in     = '0;
               blackout_in  = '0;
               hit_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_cfg_ff <= '0;
         window_ff    <= '0;
         bases_ff     <= '0;
         blackout_ff  <= '0;
         hit_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         bases_ff     <= bases_in;
         blackout_ff  <= blackout_in;
         hit_ff       <= hit_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            count_cfg_ff <= csr_write_data;
         end
      end
   end

   // Search bounds and response payload
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_has_repeat = rsp_hit_ff;

   // Probe always lies inside the open search range
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff))
      else $error("search probe outside range");

   // A new response only comes from the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response posted outside finish");

   // Finish with a free output register returns to idle with read state cleared
   a_read_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && out_free |=>
         (state_ff == ST_IDLE) && (bases_ff == '0) && !hit_ff)
      else $error("read state not cleared at read end");

endmodule
